// ----- design/cpu_list_range_parser_unit_defines.svh -----
// Assertion macros shared by the CPU list parser sources.
// Defining ASSERT_OFF leaves every assertion out; nothing else is needed.
`ifndef CPU_LIST_RANGE_PARSER_UNIT_DEFINES_SVH
`define CPU_LIST_RANGE_PARSER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Property checked at every rising clock edge outside reset.
`define CLRP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Expression that must never be true outside reset.
`define CLRP_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define CLRP_ASSERT(lbl, clk, rstn, prop, msg)
`define CLRP_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ----- design/clrp_pkg.sv -----
// Types and constants of the CPU list parser: character codes, part phases,
// controller states and the command and status groups. Depends on nothing.
package clrp_pkg;

  localparam int unsigned STORE_WORDS = 16;
  localparam int unsigned PTR_W       = 4;
  localparam int unsigned STORE_CPU_W = 10;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] INT_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] VALUE_CAP = 32'h8000_0000;
  localparam logic [3:0]  TEN       = 4'd10;

  typedef enum logic [2:0] {
    PH_EMPTY,
    PH_SPACE,
    PH_SIGN,
    PH_DIGITS,
    PH_BAD
  } part_phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_EMIT
  } clrp_state_e;

  typedef struct packed {
    logic take;
    logic fill_step;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic fill_req;
    logic fill_done;
    logic emit_final;
    logic slot_free;
  } status_t;

endpackage

// ----- design/clrp_ctrl.sv -----
// Controller of the CPU list parser: sequences word acceptance, range fills
// and result emission. Depends on clrp_pkg.
module clrp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  input  clrp_pkg::status_t status_i,
  output logic             ready_o,
  output clrp_pkg::cmd_t   cmd_o
);
  import clrp_pkg::*;

  clrp_state_e state_q, state_d;
  logic        end_pend_q, end_pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      end_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      end_pend_q <= end_pend_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    end_pend_d = end_pend_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.fill_req) begin
            state_d    = ST_FILL;
            end_pend_d = in_last_i;
          end else if (in_last_i) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_FILL: begin
        if (status_i.fill_done) begin
          state_d = end_pend_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (status_i.slot_free && status_i.emit_final) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ready_o         = 1'b0;
    cmd_o.take      = 1'b0;
    cmd_o.fill_step = 1'b0;
    cmd_o.emit_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        ready_o    = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_FILL: cmd_o.fill_step = 1'b1;
      ST_EMIT: cmd_o.emit_load = status_i.slot_free;
      default: ready_o = 1'b0;
    endcase
  end

endmodule

// ----- design/clrp_datapath.sv -----
// Datapath of the CPU list parser: part parsing registers, the sixteen-word
// CPU set store, range fill masks and the output register. Depends on clrp_pkg.
module clrp_datapath #(
  parameter int unsigned SET_SIZE = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  clrp_pkg::cmd_t    cmd_i,
  input  logic [7:0]        in_char_i,
  input  logic              in_last_i,
  input  logic              out_ready_i,
  output clrp_pkg::status_t status_o,
  output logic              out_valid_o,
  output logic [3:0]        out_index_o,
  output logic [63:0]       out_word_o,
  output logic              out_bad_o,
  output logic              out_last_o
);
  import clrp_pkg::*;

  localparam int unsigned EMIT_RAW   = (SET_SIZE + 63) / 64;
  localparam int unsigned EMIT_WORDS = (EMIT_RAW > STORE_WORDS) ? STORE_WORDS : EMIT_RAW;
  localparam logic [PTR_W-1:0] PTR_FINAL = PTR_W'(EMIT_WORDS - 1);
  localparam logic [31:0] SET_LIMIT  = 32'(SET_SIZE);
  localparam logic [31:0] STORE_LIMIT = 32'(STORE_WORDS * 64);

  logic [63:0] store_q [STORE_WORDS];

  logic [31:0]  acc_q, acc_d;
  logic [31:0]  first_q, first_d;
  part_phase_e  phase_q, phase_d;
  logic         neg_q, neg_d;
  logic         second_q, second_d;
  logic         err_q, err_d;

  logic [PTR_W-1:0]       ptr_q, ptr_d;
  logic [STORE_CPU_W-1:0] fill_first_q, fill_first_d;
  logic [STORE_CPU_W-1:0] fill_last_q, fill_last_d;

  logic        out_valid_q, out_valid_d;
  logic [3:0]  out_index_q;
  logic [63:0] out_word_q;
  logic        out_bad_q, out_last_q;

  // Value of the current part and whether it is legal.
  logic        part_ok;
  logic [31:0] part_v;
  // Outcome of closing a token.
  logic        close_err, close_fill;
  logic [31:0] close_first, close_last;
  logic        is_close, is_digit, is_space;
  logic [35:0] acc_next;
  logic        fill_done, emit_final;
  logic [5:0]  lo_bit, hi_bit;
  logic [63:0] fill_mask;

  assign is_close = in_last_i || (in_char_i == CH_COMMA);
  assign is_digit = (in_char_i >= CH_ZERO) && (in_char_i <= CH_NINE);
  assign is_space = (in_char_i == CH_SPACE) || ((in_char_i >= CH_TAB) && (in_char_i <= CH_CR));

  assign acc_next = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
                  + {32'b0, 4'(in_char_i - CH_ZERO)};

  always_comb begin
    part_ok = (phase_q == PH_EMPTY) ||
              ((phase_q == PH_DIGITS) && !(neg_q && (acc_q != '0)) && (acc_q <= INT_MAX));
    part_v  = (phase_q == PH_EMPTY) ? '0 : acc_q;
  end

  always_comb begin
    close_err   = 1'b0;
    close_fill  = 1'b0;
    close_first = part_v;
    close_last  = part_v;
    if (!part_ok) begin
      close_err = 1'b1;
    end else if (second_q) begin
      close_first = first_q;
      if ((first_q > part_v) || (part_v >= SET_LIMIT)) begin
        close_err = 1'b1;
      end else begin
        close_fill = first_q < STORE_LIMIT;
      end
    end else begin
      close_fill = (part_v < SET_LIMIT) && (part_v < STORE_LIMIT);
    end
  end

  // Range fill: one store word per cycle, mask bounded by the range ends.
  assign fill_done = (ptr_q == fill_last_q[STORE_CPU_W-1:6]);
  always_comb begin
    lo_bit    = (ptr_q == fill_first_q[STORE_CPU_W-1:6]) ? fill_first_q[5:0] : 6'd0;
    hi_bit    = fill_done ? fill_last_q[5:0] : 6'd63;
    fill_mask = ({64{1'b1}} << lo_bit) & ({64{1'b1}} >> (6'd63 - hi_bit));
  end

  assign emit_final = err_q || (ptr_q == PTR_FINAL);

  always_comb begin
    status_o.fill_req   = is_close && !err_q && !close_err && close_fill;
    status_o.fill_done  = fill_done;
    status_o.emit_final = emit_final;
    status_o.slot_free  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    acc_d        = acc_q;
    first_d      = first_q;
    phase_d      = phase_q;
    neg_d        = neg_q;
    second_d     = second_q;
    err_d        = err_q;
    ptr_d        = ptr_q;
    fill_first_d = fill_first_q;
    fill_last_d  = fill_last_q;

    if (cmd_i.take && !err_q) begin
      if (is_close) begin
        if (close_err) begin
          err_d = 1'b1;
        end else begin
          acc_d    = '0;
          phase_d  = PH_EMPTY;
          neg_d    = 1'b0;
          second_d = 1'b0;
          first_d  = '0;
          if (close_fill) begin
            fill_first_d = close_first[STORE_CPU_W-1:0];
            fill_last_d  = (close_last >= STORE_LIMIT) ? {STORE_CPU_W{1'b1}}
                                                        : close_last[STORE_CPU_W-1:0];
            ptr_d        = close_first[STORE_CPU_W-1:6];
          end
        end
      end else if (is_digit) begin
        if (phase_q != PH_BAD) begin
          acc_d   = (acc_next > {4'b0, VALUE_CAP}) ? VALUE_CAP : acc_next[31:0];
          phase_d = PH_DIGITS;
        end
      end else if (is_space) begin
        phase_d = ((phase_q == PH_EMPTY) || (phase_q == PH_SPACE)) ? PH_SPACE : PH_BAD;
      end else if ((in_char_i == CH_MINUS) && !second_q) begin
        if (!part_ok) begin
          err_d = 1'b1;
        end else begin
          first_d  = part_v;
          second_d = 1'b1;
          acc_d    = '0;
          phase_d  = PH_EMPTY;
          neg_d    = 1'b0;
        end
      end else if ((in_char_i == CH_PLUS) || (in_char_i == CH_MINUS)) begin
        if ((phase_q == PH_EMPTY) || (phase_q == PH_SPACE)) begin
          phase_d = PH_SIGN;
          neg_d   = (in_char_i == CH_MINUS);
        end else begin
          phase_d = PH_BAD;
        end
      end else begin
        phase_d = PH_BAD;
      end
    end

    if (cmd_i.fill_step) begin
      ptr_d = fill_done ? '0 : ptr_q + 1'b1;
    end

    if (cmd_i.emit_load) begin
      if (emit_final) begin
        ptr_d    = '0;
        err_d    = 1'b0;
        acc_d    = '0;
        phase_d  = PH_EMPTY;
        neg_d    = 1'b0;
        second_d = 1'b0;
        first_d  = '0;
      end else begin
        ptr_d = ptr_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      first_q      <= '0;
      phase_q      <= PH_EMPTY;
      neg_q        <= 1'b0;
      second_q     <= 1'b0;
      err_q        <= 1'b0;
      ptr_q        <= '0;
      fill_first_q <= '0;
      fill_last_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      acc_q        <= acc_d;
      first_q      <= first_d;
      phase_q      <= phase_d;
      neg_q        <= neg_d;
      second_q     <= second_d;
      err_q        <= err_d;
      ptr_q        <= ptr_d;
      fill_first_q <= fill_first_d;
      fill_last_q  <= fill_last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // The set store is cleared by reset and again after the final word of a list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_WORDS; i++) begin
        store_q[i] <= '0;
      end
    end else if (cmd_i.emit_load && emit_final) begin
      for (int i = 0; i < STORE_WORDS; i++) begin
        store_q[i] <= '0;
      end
    end else if (cmd_i.fill_step) begin
      store_q[ptr_q] <= store_q[ptr_q] | fill_mask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_index_q <= err_q ? 4'd0 : ptr_q;
      out_word_q  <= err_q ? 64'd0 : store_q[ptr_q];
      out_bad_q   <= err_q;
      out_last_q  <= emit_final;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_word_o  = out_word_q;
  assign out_bad_o   = out_bad_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- design/cpu_list_range_parser_unit.sv -----
// A comma closing a token starts a range fill over every 64-bit set word the
// token touches (up to sixteen). The end word runs its range fill, if it has one,
// then emits ceil(SET_SIZE/64) words capped at sixteen, or a single error word; a
// waiting output stalls the emission. Reset (rst_ni low, asynchronous) clears
// the set store, parse state and the output valid flag; no clearing pass is
// needed after reset.
`include "cpu_list_range_parser_unit_defines.svh"

// Top level of the CPU list parser. It joins the controller (clrp_ctrl) and
// the datapath (clrp_datapath) and uses clrp_pkg for shared types.
module cpu_list_range_parser_unit #(
  parameter int unsigned SET_SIZE = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input words: one character of the list per word.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_char
  input  logic        s_axis_tlast_i,   // end_of_list
  // Result words: one per CPU set word, or a single error word.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [3:0] word_index, [67:4] set_word, [71:68] zero
  output logic        m_axis_tuser_o,   // bad_list
  output logic        m_axis_tlast_o    // last_word
);
  import clrp_pkg::*;

  cmd_t        cmd;
  status_t     status;
  logic [3:0]  out_index;
  logic [63:0] out_word;

  // The controller only takes a word in its idle state; range fills and
  // result emission hold the input side off until they are done.
  clrp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .status_i   (status),
    .ready_o    (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  // The datapath owns the parse registers, the set store and the output
  // register, so a finished result can wait while new characters arrive.
  clrp_datapath #(
    .SET_SIZE (SET_SIZE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_char_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .out_ready_i (m_axis_tready_i),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid_o),
    .out_index_o (out_index),
    .out_word_o  (out_word),
    .out_bad_o   (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'b0, out_word, out_index};

  // An error result is always the only and final word, with an empty set.
  `CLRP_ASSERT(a_bad_is_final, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o && (m_axis_tdata_o[67:4] == 64'd0), "error word is not final or not empty")
  // The output register only fills because the datapath loaded a word.
  `CLRP_ASSERT(a_valid_from_load, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(cmd.emit_load), "output valid without a load")
  // Taking input, filling and emitting never overlap.
  `CLRP_ASSERT_NEVER(a_cmd_exclusive, clk_i, rst_ni, (cmd.take && cmd.fill_step) || (cmd.take && cmd.emit_load) || (cmd.fill_step && cmd.emit_load), "controller commands overlap")

endmodule
